/* rtl/ecr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the event energy centroid roulette unit.
// No dependencies; imported by every module of the block.
package ecr_pkg;

  localparam int POS_W    = 16;
  localparam int ENERGY_W = 16;
  localparam int PHI_W    = 16;
  localparam int THETA_W  = 15;
  localparam int TOTAL_W  = 24;
  localparam int TALLY_W  = 16;
  localparam int SUM_W    = 48;
  localparam int FACTOR_W = 16;

  // Item command codes
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_HIT     = 2'd1;
  localparam logic [1:0] CMD_SCATTER = 2'd2;
  localparam logic [1:0] CMD_END     = 2'd3;

  // Scatter kinds
  localparam logic [1:0] SCAT_COMPTON  = 2'd0;
  localparam logic [1:0] SCAT_RAYLEIGH = 2'd1;

  typedef struct packed {
    logic [1:0]                 command;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic [ENERGY_W-1:0]        energy;
    logic                       from_primary;
    logic [1:0]                 scatter_kind;
    logic signed [PHI_W-1:0]    entry_phi_in;
    logic [THETA_W-1:0]         entry_theta_in;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]    entry_x;
    logic signed [POS_W-1:0]    entry_y;
    logic signed [PHI_W-1:0]    entry_phi;
    logic [THETA_W-1:0]         entry_theta;
    logic [ENERGY_W-1:0]        entry_energy;
    logic signed [POS_W-1:0]    centroid_x;
    logic signed [POS_W-1:0]    centroid_y;
    logic [TOTAL_W-1:0]         detected_energy;
    logic [TALLY_W-1:0]         compton_count;
    logic [TALLY_W-1:0]         rayleigh_count;
    logic                       prim_deposit;
    logic                       sec_deposit;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic start_evt;
    logic mul;
    logic acc;
    logic scatter;
    logic roul_reset;
    logic roul_inc;
    logic div_start;
    logic div_sel_y;
    logic cap_x;
    logic cap_y;
    logic clr_cent;
    logic load_out;
  } ecr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic energy_zero;
    logic total_zero;
    logic roul_match;
    logic div_done;
    logic out_free;
  } ecr_stat_t;

endpackage

/* rtl/event_energy_centroid_roulette_unit.sv */
`timescale 1ns / 1ps
// Top level of the event energy centroid roulette unit.
// Uses ecr_pkg, ecr_ctrl, ecr_dp.

// Takes one event as a stream of items: start, crystal hits, scatters, end.
// Start, scatter, a zero-energy hit and an end of an event without energy
// that is not emitted are handled in the idle state; an emitted end of an
// event without energy goes on to the load state and waits there while the
// output register is full. A crystal hit with energy runs a registered 16x17
// multiply, then the saturating accumulate. An end of an event with energy
// runs the shared one-bit-per-cycle divider twice, for x then y, and then
// passes the load state before the result item sits in the output register.
// The output register lets the next event start while a result waits; a
// second result waits in the load state until the first is taken.
// roulette_factor is written through cfg_wen / cfg_wdata; the user must write
// it only while the block is idle, and the block itself does not enforce this.
module event_energy_centroid_roulette_unit
  import ecr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_wen,
  input  logic [FACTOR_W-1:0]  cfg_wdata
);

  ecr_cmd_t  cmd;
  ecr_stat_t stat;

  ecr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_item.command),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ecr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* rtl/ecr_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, signed dividend, unsigned divisor.
// Result truncates toward zero and saturates to signed 16. Uses ecr_pkg.
module ecr_div
  import ecr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SUM_W-1:0]    dividend,
  input  logic [TOTAL_W-1:0]         divisor,
  output logic                       done,
  output logic signed [POS_W-1:0]    quotient
);

  localparam int STEPS = SUM_W;
  localparam int CNT_W = $clog2(STEPS);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [SUM_W-1:0]     dvd;
  logic [SUM_W-1:0]     quo;
  logic [TOTAL_W-1:0]   rem;
  logic [TOTAL_W-1:0]   dsr;
  logic                 neg;

  logic [TOTAL_W:0]     trial;
  logic                 qbit;
  logic [TOTAL_W-1:0]   rem_next;
  logic [SUM_W-1:0]     mag;

  assign mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem, dvd[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, dsr});
  assign rem_next = qbit ? TOTAL_W'(trial - {1'b0, dsr}) : trial[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= mag;
        dsr  <= divisor;
        neg  <= dividend[SUM_W-1];
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        dvd <= {dvd[SUM_W-2:0], 1'b0};
        quo <= {quo[SUM_W-2:0], qbit};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Clamp the magnitude, then restore the sign
  always_comb begin
    if (neg) begin
      if (quo > SUM_W'(32768)) quotient = 16'sh8000;
      else                     quotient = -$signed(quo[POS_W-1:0]);
    end else begin
      if (quo > SUM_W'(32767)) quotient = 16'sh7FFF;
      else                     quotient = $signed(quo[POS_W-1:0]);
    end
  end

endmodule

/* rtl/ecr_dp.sv */
`timescale 1ns / 1ps
// Datapath: entry latch, weighted sums, energy total, tallies, roulette
// counter, centroid divider and the output register. Uses ecr_pkg, ecr_div.
module ecr_dp
  import ecr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  in_item_t              in_item,
  input  ecr_cmd_t              cmd,
  output ecr_stat_t             stat,
  input  logic                  cfg_wen,
  input  logic [FACTOR_W-1:0]   cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item
);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic [FACTOR_W-1:0]        factor;
  logic [FACTOR_W-1:0]        rcount;
  logic signed [SUM_W-1:0]    wx;
  logic signed [SUM_W-1:0]    wy;
  logic [TOTAL_W-1:0]         total;
  logic [TALLY_W-1:0]         compton;
  logic [TALLY_W-1:0]         rayleigh;
  logic                       prim_flag;
  logic                       sec_flag;
  logic signed [POS_W-1:0]    ent_x;
  logic signed [POS_W-1:0]    ent_y;
  logic signed [PHI_W-1:0]    ent_phi;
  logic [THETA_W-1:0]         ent_theta;
  logic [ENERGY_W-1:0]        ent_energy;
  logic signed [32:0]         prod_x;
  logic signed [32:0]         prod_y;
  logic signed [32:0]         prod_x_next;
  logic signed [32:0]         prod_y_next;
  logic [ENERGY_W-1:0]        hit_e;
  logic                       hit_prim;
  logic signed [POS_W-1:0]    cent_x;
  logic signed [POS_W-1:0]    cent_y;
  logic [TOTAL_W:0]           tsum;
  logic                       div_done;
  logic signed [POS_W-1:0]    div_q;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [32:0] p);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W-32){p[32]}}, p};
    if (s[SUM_W] != s[SUM_W-1]) return s[SUM_W] ? SUM_MIN : SUM_MAX;
    return s[SUM_W-1:0];
  endfunction

  assign prod_x_next = in_item.pos_x * $signed({1'b0, in_item.energy});
  assign prod_y_next = in_item.pos_y * $signed({1'b0, in_item.energy});
  assign tsum = {1'b0, total} + {{(TOTAL_W-ENERGY_W+1){1'b0}}, hit_e};

  ecr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel_y ? wy : wx),
    .divisor  (total),
    .done     (div_done),
    .quotient (div_q)
  );

  assign stat.energy_zero = (in_item.energy == '0);
  assign stat.total_zero  = (total == '0);
  assign stat.roul_match  = (rcount == factor);
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor     <= FACTOR_W'(1);
      rcount     <= FACTOR_W'(1);
      wx         <= '0;
      wy         <= '0;
      total      <= '0;
      compton    <= '0;
      rayleigh   <= '0;
      prim_flag  <= 1'b0;
      sec_flag   <= 1'b0;
      ent_x      <= '0;
      ent_y      <= '0;
      ent_phi    <= '0;
      ent_theta  <= '0;
      ent_energy <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wen) factor <= cfg_wdata;

      if (cmd.start_evt) begin
        wx         <= '0;
        wy         <= '0;
        total      <= '0;
        compton    <= '0;
        rayleigh   <= '0;
        prim_flag  <= 1'b0;
        sec_flag   <= 1'b0;
        ent_x      <= in_item.pos_x;
        ent_y      <= in_item.pos_y;
        ent_phi    <= in_item.entry_phi_in;
        ent_theta  <= in_item.entry_theta_in;
        ent_energy <= in_item.energy;
      end

      if (cmd.acc) begin
        wx    <= sat_add(wx, prod_x);
        wy    <= sat_add(wy, prod_y);
        total <= tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
        if (hit_prim) prim_flag <= 1'b1;
        else          sec_flag  <= 1'b1;
      end

      // other scatter kinds leave both tallies alone
      if (cmd.scatter) begin
        if (in_item.scatter_kind == SCAT_COMPTON) begin
          if (compton != '1) compton <= compton + 1'b1;
        end else if (in_item.scatter_kind == SCAT_RAYLEIGH) begin
          if (rayleigh != '1) rayleigh <= rayleigh + 1'b1;
        end
      end

      if (cmd.roul_reset)    rcount <= FACTOR_W'(1);
      else if (cmd.roul_inc) rcount <= rcount + 1'b1;

      if (cmd.load_out)        out_valid <= 1'b1;
      else if (!out_stall)     out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_x   <= prod_x_next;
      prod_y   <= prod_y_next;
      hit_e    <= in_item.energy;
      hit_prim <= in_item.from_primary;
    end
    if (cmd.clr_cent) begin
      cent_x <= '0;
      cent_y <= '0;
    end
    if (cmd.cap_x) cent_x <= div_q;
    if (cmd.cap_y) cent_y <= div_q;
    if (cmd.load_out) begin
      out_item.entry_x         <= ent_x;
      out_item.entry_y         <= ent_y;
      out_item.entry_phi       <= ent_phi;
      out_item.entry_theta     <= ent_theta;
      out_item.entry_energy    <= ent_energy;
      out_item.centroid_x      <= cent_x;
      out_item.centroid_y      <= cent_y;
      out_item.detected_energy <= total;
      out_item.compton_count   <= compton;
      out_item.rayleigh_count  <= rayleigh;
      out_item.prim_deposit    <= prim_flag;
      out_item.sec_deposit     <= sec_flag;
    end
  end

endmodule

/* rtl/ecr_ctrl.sv */
`timescale 1ns / 1ps
// Controller: event open flag and sequencing of hits, divider runs and
// result load. Uses ecr_pkg.
module ecr_ctrl
  import ecr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [1:0]  in_cmd,
  output logic        in_stall,
  input  ecr_stat_t   stat,
  output ecr_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIVX,
    ST_DIVY,
    ST_LOAD
  } state_t;

  state_t state, state_next;
  logic   event_open, event_open_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd             = '0;
    state_next      = state;
    event_open_next = event_open;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_START: begin
              if (!event_open) begin
                cmd.start_evt   = 1'b1;
                event_open_next = 1'b1;
              end
            end
            CMD_HIT: begin
              if (event_open && !stat.energy_zero) begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
              end
            end
            CMD_SCATTER: begin
              if (event_open) cmd.scatter = 1'b1;
            end
            CMD_END: begin
              if (event_open) begin
                event_open_next = 1'b0;
                if (!stat.total_zero) begin
                  cmd.div_start = 1'b1;
                  state_next    = ST_DIVX;
                end else if (stat.roul_match) begin
                  cmd.roul_reset = 1'b1;
                  cmd.clr_cent   = 1'b1;
                  state_next     = ST_LOAD;
                end else begin
                  cmd.roul_inc = 1'b1;
                end
              end
            end
          endcase
        end
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_DIVX: begin
        if (stat.div_done) begin
          cmd.cap_x     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_y = 1'b1;
          state_next    = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (stat.div_done) begin
          cmd.cap_y  = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      event_open <= 1'b0;
    end else begin
      state      <= state_next;
      event_open <= event_open_next;
    end
  end

endmodule

/* rtl/ecr_chk.sv */
`timescale 1ns / 1ps
// Port-level checks for the event energy centroid roulette unit, bound to
// the top level. Uses ecr_pkg.
module ecr_chk
  import ecr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input out_item_t  out_item
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled result changed");

  // A new result is loaded only from the busy load step
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a busy load step");

  // No energy means no centroid and no hit flags
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.detected_energy == '0) |->
      (out_item.centroid_x == '0) && (out_item.centroid_y == '0) &&
      !out_item.prim_deposit && !out_item.sec_deposit)
    else $error("empty event result carries hit data");

endmodule

bind event_energy_centroid_roulette_unit ecr_chk u_chk (.*);
